// ===== rtl/rne_pkg.sv =====
// ----------------------------------------------------------------------------
// rne_pkg
// Shared types, tables and widths for the roman numeral encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

    localparam int ValueWidth  = 12;
    localparam int LetterWidth = 8;
    localparam int StepWidth   = 4;
    localparam int AmountWidth = 10;

    localparam logic [ValueWidth-1:0] MaxValue = 12'd3999;
    localparam logic [StepWidth-1:0]  LastStep = 4'd12;

    localparam logic [LetterWidth-1:0] CharNone = 8'h00;
    localparam logic [LetterWidth-1:0] CharM    = 8'h4D;
    localparam logic [LetterWidth-1:0] CharD    = 8'h44;
    localparam logic [LetterWidth-1:0] CharC    = 8'h43;
    localparam logic [LetterWidth-1:0] CharL    = 8'h4C;
    localparam logic [LetterWidth-1:0] CharX    = 8'h58;
    localparam logic [LetterWidth-1:0] CharV    = 8'h56;
    localparam logic [LetterWidth-1:0] CharI    = 8'h49;

    // one greedy step (or an error marker) handed from front to back
    typedef struct packed {
        logic                 err;
        logic [StepWidth-1:0] step;
        logic                 last;
    } rne_token_t;

    function automatic logic [AmountWidth-1:0] step_amount(input logic [StepWidth-1:0] s);
        logic [AmountWidth-1:0] a;
        case (s)
            4'd0:    a = 10'd1000;
            4'd1:    a = 10'd900;
            4'd2:    a = 10'd500;
            4'd3:    a = 10'd400;
            4'd4:    a = 10'd100;
            4'd5:    a = 10'd90;
            4'd6:    a = 10'd50;
            4'd7:    a = 10'd40;
            4'd8:    a = 10'd10;
            4'd9:    a = 10'd9;
            4'd10:   a = 10'd5;
            4'd11:   a = 10'd4;
            default: a = 10'd1;
        endcase
        return a;
    endfunction

    function automatic logic [LetterWidth-1:0] first_letter(input logic [StepWidth-1:0] s);
        logic [LetterWidth-1:0] c;
        case (s)
            4'd0:    c = CharM;
            4'd1:    c = CharC;
            4'd2:    c = CharD;
            4'd3:    c = CharC;
            4'd4:    c = CharC;
            4'd5:    c = CharX;
            4'd6:    c = CharL;
            4'd7:    c = CharX;
            4'd8:    c = CharX;
            4'd9:    c = CharI;
            4'd10:   c = CharV;
            default: c = CharI;
        endcase
        return c;
    endfunction

    function automatic logic [LetterWidth-1:0] second_letter(input logic [StepWidth-1:0] s);
        logic [LetterWidth-1:0] c;
        case (s)
            4'd1:    c = CharM;
            4'd3:    c = CharD;
            4'd5:    c = CharC;
            4'd7:    c = CharL;
            4'd9:    c = CharX;
            4'd11:   c = CharV;
            default: c = CharNone;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/rne_front.sv =====
// ----------------------------------------------------------------------------
// rne_front
// Takes a request, checks its range and walks the greedy steps, pushing one
// token per numeral group into the queue.
// ----------------------------------------------------------------------------
module rne_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rne_pkg::ValueWidth-1:0] value,
    output logic                          busy,
    input  logic                          full,
    output logic                          push,
    output rne_pkg::rne_token_t           token
);
    import rne_pkg::*;

    logic                  active_reg, active_next;
    logic                  err_reg, err_next;
    logic [ValueWidth-1:0] rem_reg, rem_next;
    logic [StepWidth-1:0]  step_reg, step_next;

    logic [ValueWidth-1:0] amount;
    logic                  fits;
    logic [ValueWidth-1:0] diff;

    assign amount = {{(ValueWidth-AmountWidth){1'b0}}, step_amount(step_reg)};
    assign fits   = rem_reg >= amount;
    assign diff   = rem_reg - amount;
    assign busy   = active_reg;

    always_comb
    begin
        active_next = active_reg;
        err_next    = err_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        push        = 1'b0;
        token.err   = err_reg;
        token.step  = step_reg;
        token.last  = err_reg || (diff == '0);
        if (!active_reg)
        begin
            if (start)
            begin
                active_next = 1'b1;
                err_next    = (value == '0) || (value > MaxValue);
                rem_next    = value;
                step_next   = '0;
            end
        end
        else if (!full)
        begin
            if (err_reg)
            begin
                push        = 1'b1;
                active_next = 1'b0;
            end
            else if (fits)
            begin
                push     = 1'b1;
                rem_next = diff;
                if (diff == '0)
                begin
                    active_next = 1'b0;
                end
            end
            else if (step_reg != LastStep)
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg  <= err_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
    end

endmodule

// ===== rtl/rne_fifo.sv =====
// ----------------------------------------------------------------------------
// rne_fifo
// Short token queue between the front and back parts.
// ----------------------------------------------------------------------------
module rne_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rne_pkg::rne_token_t din,
    input  logic                pop,
    output rne_pkg::rne_token_t dout,
    output logic                empty,
    output logic                full
);
    import rne_pkg::*;

    localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntWidth = $clog2(DEPTH + 1);
    localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(DEPTH - 1);
    localparam logic [CntWidth-1:0] CntFull = CntWidth'(DEPTH);

    rne_token_t            mem [DEPTH];
    logic [PtrWidth-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CntWidth-1:0]   count_reg;
    logic                  do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CntFull);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/rne_back.sv =====
// ----------------------------------------------------------------------------
// rne_back
// Pops tokens and sends their one or two letters, one per cycle while queued.
// ----------------------------------------------------------------------------
module rne_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           empty,
    input  rne_pkg::rne_token_t            head,
    output logic                           pop,
    output logic                           strobe,
    output logic [rne_pkg::LetterWidth-1:0] letter,
    output logic                           last,
    output logic                           error
);
    import rne_pkg::*;

    logic                   cur_valid_reg;
    logic                   phase_reg;
    rne_token_t             cur_reg;
    logic                   strobe_reg;
    logic [LetterWidth-1:0] letter_reg;
    logic                   last_reg, error_reg;

    logic                   has_second;
    logic                   finishing;

    assign has_second = !cur_reg.err && (second_letter(cur_reg.step) != CharNone);
    assign finishing  = cur_valid_reg && (phase_reg || !has_second);
    assign pop        = !empty && (!cur_valid_reg || finishing);

    assign strobe = strobe_reg;
    assign letter = letter_reg;
    assign last   = last_reg;
    assign error  = error_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            strobe_reg <= cur_valid_reg;
            if (cur_valid_reg && !finishing)
            begin
                phase_reg <= 1'b1;
            end
            else
            begin
                cur_valid_reg <= pop;
                phase_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        if (cur_reg.err)
        begin
            letter_reg <= CharNone;
        end
        else
        begin
            letter_reg <= phase_reg ? second_letter(cur_reg.step)
                                    : first_letter(cur_reg.step);
        end
        last_reg  <= cur_reg.last && (phase_reg || !has_second);
        error_reg <= cur_reg.err;
    end

endmodule

// ===== rtl/roman_numeral_encoder.sv =====
// ----------------------------------------------------------------------------
// roman_numeral_encoder
// Converts a 12-bit number to its roman numeral as a run of ASCII letters.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The front part then
// latches the value, after which busy stays high while it pushes one token
// per numeral group and steps past each skipped greedy step, and also while
// the token queue is full; a new request may be taken while earlier letters
// still drain. Letters leave from the back part one per cycle on strobe while
// the queue holds tokens, with last on the final letter of a request; the
// receiver cannot stall, and a request of 0 or above 3999 gives a single
// strobe with error and last set and letter 0. The token queue of QUEUE_DEPTH
// entries lets the front run ahead of the back.
module roman_numeral_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [rne_pkg::ValueWidth-1:0]  value,
    output logic                           strobe,
    output logic [rne_pkg::LetterWidth-1:0] letter,
    output logic                           last,
    output logic                           error
);
    import rne_pkg::*;

    rne_token_t push_token, head_token;
    logic       push, pop, empty, full;

    rne_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .value (value),
        .busy  (busy),
        .full  (full),
        .push  (push),
        .token (push_token)
    );

    rne_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_token),
        .pop   (pop),
        .dout  (head_token),
        .empty (empty),
        .full  (full)
    );

    rne_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .head   (head_token),
        .pop    (pop),
        .strobe (strobe),
        .letter (letter),
        .last   (last),
        .error  (error)
    );

    // an error result is always a single, final, empty letter
    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && error |-> last && (letter == CharNone))
        else $error("error result not marked last or letter not zero");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("front not busy after accepting a request");

    // the queue can never be popped while empty or pushed while full
    a_queue_guard: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty) && !(push && full))
        else $error("token queue under- or overflow");

    // a valid letter is never zero
    a_letter_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !error |-> letter != CharNone)
        else $error("zero letter on a valid result");

endmodule
